@@ rtl/core/brbs_pkg.sv @@
// brbs_pkg: shared types, constants and codes for the byte ring buffer with search
// no dependencies
package brbs_pkg;

	localparam int DEPTH_DEF       = 4096;
	localparam int MAX_PATTERN_DEF = 8;

	localparam logic [2:0] OP_PUSH    = 3'd0;
	localparam logic [2:0] OP_POP     = 3'd1;
	localparam logic [2:0] OP_PEEK    = 3'd2;
	localparam logic [2:0] OP_OVWR    = 3'd3;
	localparam logic [2:0] OP_DISC_S  = 3'd4;
	localparam logic [2:0] OP_DISC_UP = 3'd5;
	localparam logic [2:0] OP_CLEAR   = 3'd6;
	localparam logic [2:0] OP_FIND    = 3'd7;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_DATA    = 3'd1;
	localparam logic [2:0] ST_FULL       = 3'd2;
	localparam logic [2:0] ST_NOT_ENOUGH = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  data_byte;
		logic [11:0] offset;
		logic [12:0] amount;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic        byte_valid;
		logic [2:0]  status;
		logic [12:0] scanned_length;
		logic [12:0] level;
	} out_item_t;

endpackage

@@ rtl/core/brbs_ram.sv @@
// brbs_ram: generic single-port write, single-port read RAM with registered read
// no dependencies
module brbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/brbs_queue.sv @@
// brbs_queue: two-entry queue between front and back
// depends on brbs_pkg
module brbs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  brbs_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output brbs_pkg::in_item_t out_item
);
	brbs_pkg::in_item_t ent_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_item  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) ent_q[wr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wr_q <= ~wr_q;
			if (out_valid && out_ready) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
		end
	end
endmodule

@@ rtl/core/brbs_back.sv @@
// brbs_back: executes operations on the ring, runs the byte-wise pattern scan
// depends on brbs_pkg, brbs_ram
module brbs_back #(
	parameter int MAX_PATTERN = brbs_pkg::MAX_PATTERN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  brbs_pkg::in_item_t op_item,
	input  logic [63:0]        pat_bytes,
	input  logic [3:0]         pat_len,
	output logic               res_valid,
	input  logic               res_ready,
	output brbs_pkg::out_item_t res_item
);
	localparam int DEPTH = brbs_pkg::DEPTH_DEF;
	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);
	localparam logic [3:0] MAXP = 4'(MAX_PATTERN);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;

	logic [2:0]    state_q;
	logic [AW-1:0] rp_q, wp_q;
	logic [LW-1:0] lvl_q;
	logic [LW-1:0] s_q;      // candidate start
	logic [3:0]    k_q;      // byte within candidate
	logic [3:0]    len_q;
	logic          rvld_q;   // ram read issued last cycle
	brbs_pkg::out_item_t res_q;
	logic          res_v_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    rdata;

	brbs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(op_item.data_byte),
		.raddr(raddr), .rdata(rdata)
	);

	logic full, empty;
	logic [LW-1:0] off_x, amt_x, lvl_m;
	logic [LW-1:0] disc_n;
	logic [3:0]    len_c;
	logic [7:0]    pbyte;
	logic [LW:0]   s_end;

	assign full  = lvl_q == LW'(DEPTH);
	assign empty = lvl_q == '0;
	assign off_x = LW'(op_item.offset);
	assign amt_x = LW'(op_item.amount);
	assign disc_n = (amt_x < lvl_q) ? amt_x : lvl_q;
	assign len_c = (pat_len > MAXP) ? MAXP : pat_len;
	assign pbyte = pat_bytes[{k_q[2:0], 3'b000} +: 8];
	assign lvl_m = lvl_q;
	assign s_end = (LW+1)'(s_q) + (LW+1)'(len_q);

	assign op_ready = (state_q == S_IDLE) && !res_v_q;
	assign res_valid = res_v_q;
	assign res_item  = res_q;

	logic take;
	assign take = op_valid && op_ready;

	// write port: push at wp, overwrite at rp+offset
	always_comb begin
		we = take && ((op_item.op == brbs_pkg::OP_PUSH && !full) ||
			op_item.op == brbs_pkg::OP_OVWR);
		waddr = (op_item.op == brbs_pkg::OP_PUSH) ? wp_q : AW'(rp_q + AW'(op_item.offset));
		if (state_q == S_IDLE) begin
			raddr = (op_item.op == brbs_pkg::OP_POP || op_item.op == brbs_pkg::OP_FIND) ?
				rp_q : AW'(rp_q + AW'(op_item.offset));
		end else begin
			raddr = AW'(rp_q + AW'(s_q) + AW'(k_q));
		end
	end

	function automatic brbs_pkg::out_item_t mk(logic [2:0] st, logic [12:0] sc,
		logic [LW-1:0] lv);
		brbs_pkg::out_item_t r;
		r.read_byte = 8'd0;
		r.byte_valid = 1'b0;
		r.status = st;
		r.scanned_length = sc;
		r.level = 13'(lv);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (take) begin
			unique case (op_item.op)
				brbs_pkg::OP_PUSH:    res_q <= mk(full ? brbs_pkg::ST_FULL : brbs_pkg::ST_OK,
					13'd0, full ? lvl_q : LW'(lvl_q + 1'b1));
				brbs_pkg::OP_POP:     res_q <= mk(empty ? brbs_pkg::ST_NO_DATA : brbs_pkg::ST_OK,
					13'd0, empty ? lvl_q : LW'(lvl_q - 1'b1));
				brbs_pkg::OP_PEEK:    res_q <= mk((off_x >= lvl_q) ? brbs_pkg::ST_NO_DATA :
					brbs_pkg::ST_OK, 13'd0, lvl_q);
				brbs_pkg::OP_OVWR:    res_q <= mk(brbs_pkg::ST_OK, 13'd0, lvl_q);
				brbs_pkg::OP_DISC_S:  res_q <= mk((amt_x > lvl_q || op_item.amount > 13'(DEPTH))
					? brbs_pkg::ST_NOT_ENOUGH : brbs_pkg::ST_OK, 13'd0,
					(amt_x > lvl_q || op_item.amount > 13'(DEPTH)) ? lvl_q : LW'(lvl_q - amt_x));
				brbs_pkg::OP_DISC_UP: res_q <= mk(brbs_pkg::ST_OK, 13'd0, LW'(lvl_q - disc_n));
				brbs_pkg::OP_CLEAR:   res_q <= mk(brbs_pkg::ST_OK, 13'd0, '0);
				brbs_pkg::OP_FIND:    res_q <= mk(len_c == 4'd0 ? brbs_pkg::ST_OK :
					brbs_pkg::ST_NOT_FOUND, 13'd0, lvl_q);
				default:              res_q <= mk(brbs_pkg::ST_OK, 13'd0, lvl_q);
			endcase
		end else if (state_q == S_RD) begin
			res_q.read_byte <= rdata;
			res_q.byte_valid <= 1'b1;
		end else if (state_q == S_SCAN && rvld_q) begin
			if (rdata == pbyte && k_q == len_q - 4'd1) begin
				res_q.status <= brbs_pkg::ST_OK;
				res_q.scanned_length <= 13'(s_end);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rp_q <= '0;
			wp_q <= '0;
			lvl_q <= '0;
			s_q <= '0;
			k_q <= '0;
			len_q <= '0;
			rvld_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			if (res_v_q && res_ready) res_v_q <= 1'b0;
			rvld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (take) begin
					case (op_item.op)
						brbs_pkg::OP_PUSH: begin
							if (!full) begin
								wp_q <= AW'(wp_q + 1'b1);
								lvl_q <= LW'(lvl_q + 1'b1);
							end
							res_v_q <= 1'b1;
						end
						brbs_pkg::OP_POP: begin
							if (!empty) begin
								rp_q <= AW'(rp_q + 1'b1);
								lvl_q <= LW'(lvl_q - 1'b1);
								state_q <= S_RD;
							end else res_v_q <= 1'b1;
						end
						brbs_pkg::OP_PEEK: begin
							if (off_x < lvl_q) state_q <= S_RD;
							else res_v_q <= 1'b1;
						end
						brbs_pkg::OP_DISC_S: begin
							if (!(amt_x > lvl_q || op_item.amount > 13'(DEPTH))) begin
								rp_q <= AW'(rp_q + AW'(amt_x));
								lvl_q <= LW'(lvl_q - amt_x);
							end
							res_v_q <= 1'b1;
						end
						brbs_pkg::OP_DISC_UP: begin
							rp_q <= AW'(rp_q + AW'(disc_n));
							lvl_q <= LW'(lvl_q - disc_n);
							res_v_q <= 1'b1;
						end
						brbs_pkg::OP_CLEAR: begin
							rp_q <= '0;
							wp_q <= '0;
							lvl_q <= '0;
							res_v_q <= 1'b1;
						end
						brbs_pkg::OP_FIND: begin
							len_q <= len_c;
							s_q <= '0;
							k_q <= '0;
							if (len_c == 4'd0 || (LW+1)'(len_c) > (LW+1)'(lvl_m))
								res_v_q <= 1'b1;
							else begin
								state_q <= S_SCAN;
								rvld_q <= 1'b1;
							end
						end
						default: res_v_q <= 1'b1;
					endcase
				end
				S_RD: begin
					state_q <= S_IDLE;
					res_v_q <= 1'b1;
				end
				S_SCAN: begin
					// compare on the cycle after a read, issue the next read the cycle after that
					if (rvld_q) begin
						if (rdata == pbyte) begin
							if (k_q == len_q - 4'd1) begin
								state_q <= S_IDLE;
								res_v_q <= 1'b1;
							end else begin
								k_q <= k_q + 4'd1;
							end
						end else if ((LW+1)'(s_q) + (LW+1)'(len_q) >= (LW+1)'(lvl_q)) begin
							state_q <= S_IDLE;
							res_v_q <= 1'b1;
						end else begin
							s_q <= LW'(s_q + 1'b1);
							k_q <= '0;
						end
					end else begin
						rvld_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/byte_ring_buffer_with_search.sv @@
// byte_ring_buffer_with_search: top level with apb register file, queue and back end
// depends on brbs_pkg, brbs_queue, brbs_back
//
// channel  direction  handshake          payload
// in       input      in_valid/in_ready  brbs_pkg::in_item_t
// out      output     out_valid/out_ready brbs_pkg::out_item_t
// apb      input      psel/penable       pattern registers at 0x0 and 0x8
//
// push, discard and clear return their result straight from idle, pop and peek go through S_RD (ram read)
// find alternates a ram read and a byte compare, at most level*len compares
// the back end handles one operation at a time; the two-entry queue absorbs input
// reset clears pointers and level; the byte store is not cleared
module byte_ring_buffer_with_search #(
	parameter int MAX_PATTERN = brbs_pkg::MAX_PATTERN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  brbs_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output brbs_pkg::out_item_t out_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [63:0]         pwdata,
	output logic [63:0]         prdata,
	output logic                pready
);
	logic [63:0] pat_q;
	logic [3:0]  len_q;

	assign pready = 1'b1;
	assign prdata = paddr[3] ? {60'd0, len_q} : pat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= 4'd1;
		end else if (psel && penable && pwrite) begin
			if (paddr == 4'h0) pat_q <= pwdata;
			else if (paddr == 4'h8) len_q <= pwdata[3:0];
		end
	end

	logic q_valid, q_ready;
	brbs_pkg::in_item_t q_item;

	brbs_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
	);

	brbs_back #(.MAX_PATTERN(MAX_PATTERN)) u_back (
		.clk(clk), .arst_n(arst_n),
		.op_valid(q_valid), .op_ready(q_ready), .op_item(q_item),
		.pat_bytes(pat_q), .pat_len(len_q),
		.res_valid(out_valid), .res_ready(out_ready), .res_item(out_item)
	);

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.level <= 13'(brbs_pkg::DEPTH_DEF))
		else $error("level beyond depth");
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.byte_valid |-> out_item.status == brbs_pkg::ST_OK)
		else $error("byte valid with error status");
	a_scan_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.scanned_length != 13'd0 |-> out_item.status == brbs_pkg::ST_OK)
		else $error("scan length with error");
endmodule
